// ===== rtl/elementary_cellular_automaton_defines.svh =====
// Assertion macros for the elementary cellular automaton block.
// Used by files that check their own logic; expects clk and arst_n in scope.
`ifndef ELEMENTARY_CELLULAR_AUTOMATON_DEFINES_SVH
`define ELEMENTARY_CELLULAR_AUTOMATON_DEFINES_SVH

// same-cycle implication
`define ECA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ECA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/eca_pkg.sv =====
// Shared constants, types and the rule function of the cellular automaton.
// No dependencies.
package eca_pkg;

	localparam int ROW_WORDS  = 16;
	localparam int WORD_W     = 64;
	localparam int WCNT_W     = $clog2(ROW_WORDS + 1);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int RW_W       = 5;
	localparam int GEN_W      = 16;

	localparam logic [CFG_IDX_W-1:0] REG_RULE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_EDGE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_EDGE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GENERATIONS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_WORDS   = 3'd4;

	typedef struct packed {
		logic load;
		logic step;
		logic shift;
	} cell_ctrl_t;

	function automatic logic [WORD_W-1:0] eca_next(
		input logic [7:0]        rule,
		input logic [WORD_W-1:0] l,
		input logic [WORD_W-1:0] s,
		input logic [WORD_W-1:0] r
	);
		logic [WORD_W-1:0] nx;
		nx = '0;
		for (int b = 0; b < WORD_W; b++) begin
			nx[b] = rule[{l[b], s[b], r[b]}];
		end
		return nx;
	endfunction

endpackage

// ===== rtl/elementary_cellular_automaton.sv =====
// Operation: row_words input beats load the row; the generations then run, one per cycle,
// after which the first result beat is offered; one result beat per cycle thereafter
// while out_ready is high. No input is taken while generations run or results drain.
// Reset clears control and configuration (generations 1, row_words 16); the cell words
// are not cleared.
`include "elementary_cellular_automaton_defines.svh"
module elementary_cellular_automaton
	import eca_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [WORD_W-1:0]     cell_word,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [WORD_W-1:0]     result_word,
	output logic                  last_word
);

	typedef enum logic [2:0] {
		ST_LOAD = 3'b001,
		ST_RUN  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	localparam int CW = (WCNT_W > RW_W) ? WCNT_W : RW_W;

	state_t             state_q;
	logic [7:0]         rule_q;
	logic               left_edge_q;
	logic               right_edge_q;
	logic [GEN_W-1:0]   generations_q;
	logic [RW_W-1:0]    row_words_q;
	logic [WCNT_W-1:0]  load_count_q;
	logic [WCNT_W-1:0]  n_q;
	logic [WCNT_W-1:0]  rem_q;
	logic [GEN_W-1:0]   gen_q;

	logic [CW-1:0]      rw_ext;
	logic [WCNT_W-1:0]  n_now;
	logic [WCNT_W-1:0]  idx;
	logic               in_acc;
	logic               out_acc;
	logic               load_last;
	cell_ctrl_t         ctrl;
	logic [WORD_W-1:0]  words [ROW_WORDS];

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q        <= '0;
			left_edge_q   <= 1'b0;
			right_edge_q  <= 1'b0;
			generations_q <= GEN_W'(1);
			row_words_q   <= RW_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RULE:        rule_q        <= cfg_data[7:0];
				REG_LEFT_EDGE:   left_edge_q   <= cfg_data[0];
				REG_RIGHT_EDGE:  right_edge_q  <= cfg_data[0];
				REG_GENERATIONS: generations_q <= cfg_data[GEN_W-1:0];
				REG_ROW_WORDS:   row_words_q   <= cfg_data[RW_W-1:0];
				default: ;
			endcase
		end
	end

	// active row length, clamped to 1..ROW_WORDS
	assign rw_ext = CW'(row_words_q);
	always_comb begin
		if (rw_ext == '0) begin
			n_now = WCNT_W'(1);
		end else if (rw_ext > CW'(ROW_WORDS)) begin
			n_now = WCNT_W'(ROW_WORDS);
		end else begin
			n_now = WCNT_W'(rw_ext);
		end
	end

	assign idx       = (load_count_q >= n_now) ? n_now - WCNT_W'(1) : load_count_q;
	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_EMIT);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign load_last = (idx == n_now - WCNT_W'(1));

	assign ctrl.load  = in_acc;
	assign ctrl.step  = (state_q == ST_RUN);
	assign ctrl.shift = out_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			load_count_q <= '0;
			n_q          <= WCNT_W'(1);
			rem_q        <= '0;
			gen_q        <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (load_last) begin
							load_count_q <= '0;
							n_q          <= n_now;
							rem_q        <= n_now - WCNT_W'(1);
							gen_q        <= generations_q;
							state_q      <= (generations_q == '0) ? ST_EMIT : ST_RUN;
						end else begin
							load_count_q <= idx + WCNT_W'(1);
						end
					end
				end
				ST_RUN: begin
					gen_q <= gen_q - GEN_W'(1);
					if (gen_q == GEN_W'(1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						rem_q <= rem_q - WCNT_W'(1);
						if (rem_q == '0) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// chain of word cells
	for (genvar w = 0; w < ROW_WORDS; w++) begin : g_cell
		logic lin;
		logic rin;
		logic [WORD_W-1:0] sh;
		if (w == 0) begin : g_first
			assign lin = left_edge_q;
		end else begin : g_mid_l
			assign lin = words[w-1][WORD_W-1];
		end
		if (w == ROW_WORDS - 1) begin : g_last
			assign rin = right_edge_q;
			assign sh  = '0;
		end else begin : g_mid_r
			assign rin = (n_q == WCNT_W'(w + 1)) ? right_edge_q : words[w+1][0];
			assign sh  = words[w+1];
		end
		eca_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.sel        (idx == WCNT_W'(w)),
			.rule       (rule_q),
			.left_in    (lin),
			.right_in   (rin),
			.load_word  (cell_word),
			.shift_word (sh),
			.word       (words[w])
		);
	end

	assign result_word = words[0];
	assign last_word   = (rem_q == '0);

	`ECA_ASSERT_NOW(a_no_overlap, 1'b1, !(in_ready && out_valid), "load and emit overlap")
	`ECA_ASSERT_NEXT(a_row_done, in_acc && load_last, !in_ready, "row complete but still loading")
	`ECA_ASSERT_NEXT(a_back_to_load, out_acc && last_word, in_ready, "last beat did not end the row")
	`ECA_ASSERT_NOW(a_run_count, state_q == ST_RUN, gen_q != '0, "generation count ran out")

endmodule

// ===== rtl/eca_cell.sv =====
// One 64-cell word of the row: load, one-generation update or shift towards word 0.
// Depends on eca_pkg.
module eca_cell
	import eca_pkg::*;
(
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic              sel,
	input  logic [7:0]        rule,
	input  logic              left_in,
	input  logic              right_in,
	input  logic [WORD_W-1:0] load_word,
	input  logic [WORD_W-1:0] shift_word,
	output logic [WORD_W-1:0] word
);

	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] next_w;

	assign next_w = eca_next(rule, {word_q[WORD_W-2:0], left_in}, word_q,
		{right_in, word_q[WORD_W-1:1]});

	always_ff @(posedge clk) begin
		if (ctrl.load && sel) begin
			word_q <= load_word;
		end else if (ctrl.step) begin
			word_q <= next_w;
		end else if (ctrl.shift) begin
			word_q <= shift_word;
		end
	end

	assign word = word_q;

endmodule
